@@ hw/rtl/ierb_pkg.sv @@
// ----------------------------------------------------------------------------
// ierb_pkg: shared types and constants of the input event ring buffer
// Payload structs, operation and status codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ierb_pkg;

  localparam int CAPACITY_DEF = 64;
  localparam int RESULT_LIMIT = 64;

  // operation kinds
  localparam logic [2:0] KIND_PUSH    = 3'd0;
  localparam logic [2:0] KIND_READ    = 3'd1;
  localparam logic [2:0] KIND_PEEK    = 3'd2;
  localparam logic [2:0] KIND_COUNT   = 3'd3;
  localparam logic [2:0] KIND_ACQUIRE = 3'd4;
  localparam logic [2:0] KIND_RELEASE = 3'd5;

  // result status codes
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_NOT_ACQUIRED = 3'd1;
  localparam logic [2:0] ST_NOT_BUFFERED = 3'd2;
  localparam logic [2:0] ST_ALREADY      = 3'd3;
  localparam logic [2:0] ST_NO_EFFECT    = 3'd4;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  object_offset;
    logic [31:0] event_value;
    logic [31:0] time_stamp;
    logic [6:0]  max_entries;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic        entry_valid;
    logic [7:0]  entry_offset;
    logic [31:0] entry_data;
    logic [31:0] entry_time;
    logic [31:0] entry_number;
    logic [6:0]  held_count;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  offset;
    logic [31:0] value;
    logic [31:0] stamp;
    logic [31:0] number;
  } slot_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_DRAIN
  } ctrl_state_t;

  typedef struct packed {
    logic latch_item;    // capture accepted transaction
    logic finish_single; // emit the one result and apply its state change
    logic start_drain;   // capture entry count for a read/peek
    logic emit_entry;    // emit one entry result
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;      // output register can take a result this cycle
    logic need_drain;    // latched item returns entries
    logic last_entry;    // next entry result is the final one
  } dp_stat_t;

endpackage

`default_nettype wire

@@ hw/rtl/input_event_ring_buffer.sv @@
// ----------------------------------------------------------------------------
// input_event_ring_buffer: buffered input event FIFO, drop-oldest on overflow
// Push, read, peek, count, acquire and release on one transaction channel.
// ----------------------------------------------------------------------------
// One transaction is handled at a time. A transaction that gives one result
// (push, count, acquire, release, or a read/peek with nothing to return)
// is accepted and then executed into the output register. A read or peek
// returns its entries one per cycle while the output is not stalled, from the
// registered read port of the CAPACITY-deep slot memory. The next
// transaction is accepted while the last result still waits in the output
// register. Slot memory is not cleared after reset; only slots holding
// entries are ever returned. The size register only enables buffering when
// non-zero; the ring always holds up to CAPACITY entries.
`default_nettype none

module input_event_ring_buffer #(
  parameter int CAPACITY = ierb_pkg::CAPACITY_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ierb_pkg::in_item_t   in_item,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output ierb_pkg::out_item_t       out_item,
  input  wire logic                 cfg_we,
  input  wire logic [6:0]           cfg_wdata
);

  ierb_pkg::ctrl_cmd_t cmd;
  ierb_pkg::dp_stat_t  stat;

  ierb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .cmd      (cmd)
  );

  ierb_dp #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cmd       (cmd),
    .stat      (stat)
  );

endmodule

`default_nettype wire

@@ hw/rtl/ierb_ctrl.sv @@
// ----------------------------------------------------------------------------
// ierb_ctrl: transaction sequencer
// Accepts one transaction, decides single result or entry drain, and steps
// the datapath through it.
// ----------------------------------------------------------------------------
`default_nettype none

module ierb_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire ierb_pkg::dp_stat_t   stat,
  output ierb_pkg::ctrl_cmd_t       cmd
);

  ierb_pkg::ctrl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ierb_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      ierb_pkg::S_IDLE: begin
        // nothing is taken while reset is held
        in_stall = !rst_n;
        if (in_valid) begin
          cmd.latch_item = 1'b1;
          state_nxt      = ierb_pkg::S_EXEC;
        end
      end
      ierb_pkg::S_EXEC: begin
        if (stat.need_drain) begin
          cmd.start_drain = 1'b1;
          state_nxt       = ierb_pkg::S_DRAIN;
        end else if (stat.out_free) begin
          cmd.finish_single = 1'b1;
          state_nxt         = ierb_pkg::S_IDLE;
        end
      end
      ierb_pkg::S_DRAIN: begin
        if (stat.out_free) begin
          cmd.emit_entry = 1'b1;
          if (stat.last_entry) begin
            state_nxt = ierb_pkg::S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ierb_pkg::S_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

@@ hw/rtl/ierb_dp.sv @@
// ----------------------------------------------------------------------------
// ierb_dp: ring buffer datapath
// Slot memory, head/count/sequence state, acquire and enable flags, result
// decode and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ierb_dp #(
  parameter int CAPACITY = ierb_pkg::CAPACITY_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire ierb_pkg::in_item_t   in_item,
  input  wire logic                 cfg_we,
  input  wire logic [6:0]           cfg_wdata,
  input  wire logic                 out_stall,
  output logic                      out_valid,
  output ierb_pkg::out_item_t       out_item,
  input  wire ierb_pkg::ctrl_cmd_t  cmd,
  output ierb_pkg::dp_stat_t        stat
);

  localparam int PW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int NW = (CW > 7) ? CW : 7;
  localparam logic [PW-1:0] LAST_SLOT = PW'(CAPACITY - 1);
  localparam logic [CW-1:0] FULL      = CW'(CAPACITY);
  localparam logic [6:0]    LIMIT     = 7'(ierb_pkg::RESULT_LIMIT);

  ierb_pkg::in_item_t  item_r;
  ierb_pkg::out_item_t out_r, out_nxt;
  ierb_pkg::slot_t     mem [CAPACITY];
  ierb_pkg::slot_t     rd_data_r, wr_data;

  logic            en_r, en_nxt;
  logic            acq_r, acq_nxt;
  logic [PW-1:0]   head_r, head_nxt;
  logic [CW-1:0]   count_r, count_nxt;
  logic [31:0]     seq_r, seq_nxt;
  logic [6:0]      n_r, n_nxt;
  logic [6:0]      prod_r, prod_nxt;
  logic            out_valid_r, out_valid_nxt;

  logic            out_free;
  logic            wr_en;
  logic [PW-1:0]   wr_addr;
  logic [PW-1:0]   head_inc;
  logic [PW-1:0]   push_head;
  logic [PW-1:0]   push_cnt;
  logic [PW:0]     pos_sum;
  logic            full;
  logic [31:0]     count_ext;
  logic            cnt_lt;
  logic [6:0]      n_sel, n_cap, n_calc;
  logic            is_entry_kind;
  logic [2:0]      single_status;
  logic [6:0]      single_held;
  logic [6:0]      prod_inc;

  assign out_free  = !out_valid_r || !out_stall;
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  // ring arithmetic
  assign head_inc  = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
  assign full      = (count_r == FULL);
  assign push_head = full ? head_inc : head_r;
  assign push_cnt  = full ? LAST_SLOT : count_r[PW-1:0];
  assign pos_sum   = {1'b0, push_head} + {1'b0, push_cnt};
  assign wr_addr   = (pos_sum >= (PW+1)'(CAPACITY)) ?
                     PW'(pos_sum - (PW+1)'(CAPACITY)) : pos_sum[PW-1:0];

  // entries a read/peek returns
  assign count_ext = 32'(count_r);
  assign cnt_lt    = NW'(count_r) < NW'(item_r.max_entries);
  assign n_sel     = cnt_lt ? count_ext[6:0] : item_r.max_entries;
  assign n_cap     = (n_sel > LIMIT) ? LIMIT : n_sel;
  assign n_calc    = (item_r.kind == ierb_pkg::KIND_PEEK && n_cap > 7'd1) ? 7'd1 : n_cap;

  assign is_entry_kind = (item_r.kind == ierb_pkg::KIND_READ) ||
                         (item_r.kind == ierb_pkg::KIND_PEEK);
  assign prod_inc      = prod_r + 7'd1;

  assign stat.out_free   = out_free;
  assign stat.need_drain = is_entry_kind && acq_r && en_r && (n_calc != 7'd0);
  assign stat.last_entry = (prod_inc == n_r);

  assign wr_data.offset = item_r.object_offset;
  assign wr_data.value  = item_r.event_value;
  assign wr_data.stamp  = item_r.time_stamp;
  assign wr_data.number = seq_r + 32'd1;

  // single-result decode
  always_comb begin
    single_status = ierb_pkg::ST_NO_EFFECT;
    single_held   = '0;
    unique case (item_r.kind)
      ierb_pkg::KIND_PUSH: begin
        if (!en_r)       single_status = ierb_pkg::ST_NOT_BUFFERED;
        else if (!acq_r) single_status = ierb_pkg::ST_NOT_ACQUIRED;
        else             single_status = ierb_pkg::ST_OK;
      end
      ierb_pkg::KIND_READ, ierb_pkg::KIND_PEEK, ierb_pkg::KIND_COUNT: begin
        if (!acq_r)     single_status = ierb_pkg::ST_NOT_ACQUIRED;
        else if (!en_r) single_status = ierb_pkg::ST_NOT_BUFFERED;
        else begin
          single_status = ierb_pkg::ST_OK;
          if (item_r.kind == ierb_pkg::KIND_COUNT) single_held = count_ext[6:0];
        end
      end
      ierb_pkg::KIND_ACQUIRE: begin
        single_status = acq_r ? ierb_pkg::ST_ALREADY : ierb_pkg::ST_OK;
      end
      ierb_pkg::KIND_RELEASE: begin
        single_status = acq_r ? ierb_pkg::ST_OK : ierb_pkg::ST_NO_EFFECT;
      end
      default: begin
        single_status = ierb_pkg::ST_NO_EFFECT;
      end
    endcase
  end

  // state update
  always_comb begin
    en_nxt        = en_r;
    acq_nxt       = acq_r;
    head_nxt      = head_r;
    count_nxt     = count_r;
    seq_nxt       = seq_r;
    n_nxt         = n_r;
    prod_nxt      = prod_r;
    out_nxt       = out_r;
    out_valid_nxt = out_stall ? out_valid_r : 1'b0;
    wr_en         = 1'b0;

    if (cfg_we) en_nxt = (cfg_wdata != 7'd0);

    if (cmd.start_drain) begin
      n_nxt    = n_calc;
      prod_nxt = '0;
    end

    if (cmd.finish_single) begin
      out_valid_nxt = 1'b1;
      out_nxt       = '0;
      out_nxt.status     = single_status;
      out_nxt.held_count = single_held;
      out_nxt.last       = 1'b1;
      unique case (item_r.kind)
        ierb_pkg::KIND_PUSH: begin
          if (en_r && acq_r) begin
            wr_en     = 1'b1;
            head_nxt  = push_head;
            count_nxt = CW'(push_cnt) + 1'b1;
            seq_nxt   = seq_r + 32'd1;
          end
        end
        ierb_pkg::KIND_ACQUIRE: begin
          if (!acq_r) begin
            acq_nxt   = 1'b1;
            head_nxt  = '0;
            count_nxt = '0;
          end
        end
        ierb_pkg::KIND_RELEASE: begin
          acq_nxt = 1'b0;
        end
        default: begin
        end
      endcase
    end

    if (cmd.emit_entry) begin
      out_valid_nxt        = 1'b1;
      out_nxt.status       = ierb_pkg::ST_OK;
      out_nxt.entry_valid  = 1'b1;
      out_nxt.entry_offset = rd_data_r.offset;
      out_nxt.entry_data   = rd_data_r.value;
      out_nxt.entry_time   = rd_data_r.stamp;
      out_nxt.entry_number = rd_data_r.number;
      out_nxt.held_count   = prod_inc;
      out_nxt.last         = (prod_inc == n_r);
      prod_nxt             = prod_inc;
      if (item_r.kind == ierb_pkg::KIND_READ) begin
        head_nxt  = head_inc;
        count_nxt = count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      en_r        <= 1'b0;
      acq_r       <= 1'b0;
      head_r      <= '0;
      count_r     <= '0;
      seq_r       <= '0;
      out_valid_r <= 1'b0;
      n_r         <= '0;
      prod_r      <= '0;
    end else begin
      en_r        <= en_nxt;
      acq_r       <= acq_nxt;
      head_r      <= head_nxt;
      count_r     <= count_nxt;
      seq_r       <= seq_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      prod_r      <= prod_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (cmd.latch_item) item_r <= in_item;
  end

  // slot memory; read port follows the next head so the drain gets one
  // entry per cycle while the output is not stalled
  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    rd_data_r <= mem[head_nxt];
  end

endmodule

`default_nettype wire
